FILE: hdl/stpq_pkg.sv
// Shared types and constants for the stable time priority queue.
package stpq_pkg;

    // Field widths of the stream words and the default capacity.
    localparam int TIME_W           = 48;
    localparam int TAG_W            = 16;
    localparam int OCC_OUT_W        = 5;
    localparam int DEFAULT_CAPACITY = 16;

    // Operation codes carried in the input tuser.
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // Result status codes carried in the output tuser.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNSUB = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Contents of one queue slot.
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] due;
        logic [TAG_W-1:0]  tag;
    } slot_t;

    // Command broadcast to every slot for one step.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [TIME_W-1:0] due;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

endpackage

FILE: hdl/stable_time_priority_queue.sv
// Top level of the stable time priority queue: stream ports, sorted chain, result register.
// Bounded queue of timed actions kept sorted by due time in a chain of CAPACITY slot
// registers; entries with equal time leave in arrival order. Each input word is a push
// (tuser 0) or a pop (tuser 1) and yields exactly one result word, which is valid on the
// result port after the input word is taken and registered: the word sits in the input
// register while the slot compare and shift logic works on it, and the outcome is loaded
// into the result register when that is free or draining. A new word can be taken every
// cycle; the whole chain compares against the pushed time in parallel, so throughput is
// one word per clock as long as the result side keeps up. Pop on empty, push when full and
// unsubscribed pushes leave the queue unchanged and are reported in the result tuser.
module stable_time_priority_queue
    import stpq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // event_time[47:0], payload_tag[63:48], subscribed[64], zero fill[71:65]
    input  logic [71:0]  s_tdata,
    // op[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // popped_time[47:0], popped_tag[63:48], head_valid[64], head_time[112:65],
    // head_tag[128:113], occupancy[133:129], recursion_allowed[134], zero fill[135]
    output logic [135:0] m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    // Input register.
    logic              in_valid_reg;
    logic              in_op_reg;
    logic [TIME_W-1:0] in_due_reg;
    logic [TAG_W-1:0]  in_tag_reg;
    logic              in_sub_reg;

    // Result register.
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [TIME_W-1:0]    out_ptime_reg;
    logic [TAG_W-1:0]     out_ptag_reg;
    logic                 out_hvalid_reg;
    logic [TIME_W-1:0]    out_htime_reg;
    logic [TAG_W-1:0]     out_htag_reg;
    logic [OCC_OUT_W-1:0] out_occ_reg;
    logic                 out_rec_reg;

    // Queue bookkeeping.
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             rec_reg;
    logic             rec_next;

    logic    advance;
    logic    full;
    logic    empty;
    cmd_t    cmd;
    status_t status;
    logic [OCC_W+OCC_OUT_W-1:0] occ_ext;

    slot_t slot_q [CAPACITY];
    slot_t slot_d [CAPACITY];
    logic  le     [CAPACITY];

    // Handshake: the current word moves on when the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign full     = (occ_reg == OCC_W'(CAPACITY));
    assign empty    = (occ_reg == '0);

    // Decode the step and its status.
    always_comb begin
        cmd.push = 1'b0;
        cmd.pop  = 1'b0;
        cmd.due  = in_due_reg;
        cmd.tag  = in_tag_reg;
        status   = ST_OK;
        if (in_op_reg == OP_PUSH) begin
            if (!in_sub_reg) begin
                status = ST_UNSUB;
            end else if (full) begin
                status = ST_FULL;
            end else begin
                cmd.push = advance;
            end
        end else begin
            if (empty) begin
                status = ST_EMPTY;
            end else begin
                cmd.pop = advance;
            end
        end
    end

    // Occupancy and recursion flag after the step.
    always_comb begin
        occ_next = occ_reg;
        rec_next = rec_reg;
        if (cmd.push) begin
            occ_next = occ_reg + OCC_W'(1);
            rec_next = 1'b0;
        end else if (cmd.pop) begin
            occ_next = occ_reg - OCC_W'(1);
            if (occ_reg == OCC_W'(1)) begin
                rec_next = 1'b1;
            end
        end
    end

    assign occ_ext = {{OCC_OUT_W{1'b0}}, occ_next};

    // Sorted chain of slots; slot 0 is the head.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        slot_t prev_slot;
        logic  prev_le;
        slot_t next_slot;

        if (i == 0) begin : g_first
            assign prev_slot = '{valid: 1'b1, due: '0, tag: '0};
            assign prev_le   = 1'b1;
        end else begin : g_mid
            assign prev_slot = slot_q[i-1];
            assign prev_le   = le[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_slot = '{valid: 1'b0, due: '0, tag: '0};
        end else begin : g_inner
            assign next_slot = slot_q[i+1];
        end

        stpq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .prev_slot (prev_slot),
            .prev_le   (prev_le),
            .next_slot (next_slot),
            .slot      (slot_q[i]),
            .slot_next (slot_d[i]),
            .le        (le[i])
        );
    end

    // Input register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg  <= s_tuser;
            in_due_reg <= s_tdata[TIME_W-1:0];
            in_tag_reg <= s_tdata[TIME_W+TAG_W-1:TIME_W];
            in_sub_reg <= s_tdata[TIME_W+TAG_W];
        end
    end

    // Queue bookkeeping registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            rec_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            rec_reg <= rec_next;
        end
    end

    // Result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: popped entry, new head and counts.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= status;
            out_ptime_reg  <= cmd.pop ? slot_q[0].due : '0;
            out_ptag_reg   <= cmd.pop ? slot_q[0].tag : '0;
            out_hvalid_reg <= slot_d[0].valid;
            out_htime_reg  <= slot_d[0].valid ? slot_d[0].due : '0;
            out_htag_reg   <= slot_d[0].valid ? slot_d[0].tag : '0;
            out_occ_reg    <= occ_ext[OCC_OUT_W-1:0];
            out_rec_reg    <= rec_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_rec_reg, out_occ_reg, out_htag_reg, out_htime_reg,
                       out_hvalid_reg, out_ptag_reg, out_ptime_reg};

`ifndef SYNTHESIS
    // The fill count never exceeds the chain length.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    // The head slot is valid exactly when the count is nonzero.
    a_head_count: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_q[0].valid == (occ_reg != '0))
        else $error("head slot valid disagrees with occupancy");

    // A reported pop on empty leaves an empty queue behind.
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_status_reg == ST_EMPTY)) |->
        (!out_hvalid_reg && (out_occ_reg == '0)))
        else $error("pop on empty reported with entries present");
`endif

endmodule

FILE: hdl/stpq_cell.sv
// One slot of the sorted register chain: compare, hold, insert or shift.
module stpq_cell
    import stpq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cmd_t  cmd,
    input  slot_t prev_slot,
    input  logic  prev_le,
    input  slot_t next_slot,
    output slot_t slot,
    output slot_t slot_next,
    output logic  le
);

    slot_t slot_reg;

    // This slot holds an entry due no later than the pushed one.
    assign le   = slot_reg.valid && (slot_reg.due <= cmd.due);
    assign slot = slot_reg;

    // Keep, take the new entry, take from the left on push, or from the right on pop.
    always_comb begin
        slot_next = slot_reg;
        if (cmd.push) begin
            if (le) begin
                slot_next = slot_reg;
            end else if (prev_le) begin
                slot_next.valid = 1'b1;
                slot_next.due   = cmd.due;
                slot_next.tag   = cmd.tag;
            end else begin
                slot_next.valid = slot_reg.valid | prev_slot.valid;
                slot_next.due   = prev_slot.due;
                slot_next.tag   = prev_slot.tag;
            end
        end else if (cmd.pop) begin
            slot_next = next_slot;
        end
    end

    // Valid bit is control state; time and tag need no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else begin
            slot_reg.valid <= slot_next.valid;
        end
        slot_reg.due <= slot_next.due;
        slot_reg.tag <= slot_next.tag;
    end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the stable time priority queue.
module testbench;
    import stpq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};

    // One result word, split into its fields.
    typedef struct packed {
        status_t               status;
        logic [TIME_W-1:0]     popped_time;
        logic [TAG_W-1:0]      popped_tag;
        logic                  head_valid;
        logic [TIME_W-1:0]     head_time;
        logic [TAG_W-1:0]      head_tag;
        logic [OCC_OUT_W-1:0]  occupancy;
        logic                  recursion_allowed;
    } queue_result_t;

    // Keeps its own sorted copy of the queue and the results it still owes.
    class stpq_scoreboard;
        logic [TIME_W-1:0] due_q[$];
        logic [TAG_W-1:0]  tag_q[$];
        logic              recursion;
        queue_result_t     owed_q[$];
        int                mismatches;

        function new();
            recursion  = 1'b0;
            mismatches = 0;
        endfunction

        function int stored();
            return due_q.size();
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction

        // Apply one accepted input word to the queue copy and note the result it causes.
        function void note_word(op_t op, logic [TIME_W-1:0] due, logic [TAG_W-1:0] tag,
                                logic live);
            queue_result_t r;
            int            pos;
            r = '0;
            r.status = ST_OK;
            if (op == OP_PUSH) begin
                if (!live) begin
                    r.status = ST_UNSUB;
                end else if (due_q.size() >= DEFAULT_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // Equal times go behind the ones already stored.
                    pos = 0;
                    while (pos < due_q.size() && due_q[pos] <= due) pos++;
                    due_q.insert(pos, due);
                    tag_q.insert(pos, tag);
                    recursion = 1'b0;
                end
            end else begin
                if (due_q.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_time = due_q.pop_front();
                    r.popped_tag  = tag_q.pop_front();
                    if (due_q.size() == 0) recursion = 1'b1;
                end
            end
            r.head_valid = (due_q.size() != 0);
            if (r.head_valid) begin
                r.head_time = due_q[0];
                r.head_tag  = tag_q[0];
            end
            r.occupancy         = OCC_OUT_W'(due_q.size());
            r.recursion_allowed = recursion;
            owed_q.push_back(r);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s: expected %0h, got %0h", field, want, got);
            end
        endfunction

        // Compare one accepted result word with the oldest owed result.
        function void check_word(queue_result_t got);
            queue_result_t want;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d", got.status);
                return;
            end
            want = owed_q.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("popped_time", 64'(want.popped_time), 64'(got.popped_time));
            compare_field("popped_tag", 64'(want.popped_tag), 64'(got.popped_tag));
            compare_field("head_valid", 64'(want.head_valid), 64'(got.head_valid));
            compare_field("head_time", 64'(want.head_time), 64'(got.head_time));
            compare_field("head_tag", 64'(want.head_tag), 64'(got.head_tag));
            compare_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
            compare_field("recursion_allowed", 64'(want.recursion_allowed),
                          64'(got.recursion_allowed));
        endfunction
    endclass

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    // event_time[47:0], payload_tag[63:48], subscribed[64], zero fill[71:65]
    logic [71:0]    s_tdata;
    // op[0]
    logic           s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    // popped_time[47:0], popped_tag[63:48], head_valid[64], head_time[112:65],
    // head_tag[128:113], occupancy[133:129], recursion_allowed[134], zero fill[135]
    logic [135:0]   m_tdata;
    // status[1:0]
    logic [1:0]     m_tuser;

    stpq_scoreboard sb;
    int             send_idle;
    int             recv_idle;
    int unsigned    cycles;

    stable_time_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock with a period of 8.
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // The receiver stalls at random, changing its ready at the falling edge.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_idle);
    end

    // Every accepted result word goes to the scoreboard.
    always @(posedge aclk) begin
        queue_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status            = status_t'(m_tuser);
            got.popped_time       = m_tdata[47:0];
            got.popped_tag        = m_tdata[63:48];
            got.head_valid        = m_tdata[64];
            got.head_time         = m_tdata[112:65];
            got.head_tag          = m_tdata[128:113];
            got.occupancy         = m_tdata[133:129];
            got.recursion_allowed = m_tdata[134];
            sb.check_word(got);
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one input word, starting at a falling edge, and return at the falling edge
    // after it is taken.
    task automatic send_word(op_t op, logic [TIME_W-1:0] due, logic [TAG_W-1:0] tag,
                             logic live);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = {7'd0, live, tag, due};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(op, due, tag, live);
        @(negedge aclk);
    endtask

    // Random due time: often a few small values so that equal times are common.
    function automatic logic [TIME_W-1:0] pick_due();
        case ($urandom_range(4))
            0, 1:    return TIME_W'($urandom_range(7));
            2:       return TIME_W'({$urandom, $urandom});
            3:       return TIME_W'($urandom_range(1000));
            default: return $urandom_range(1) ? TIME_MAX : '0;
        endcase
    endfunction

    // Random words that swing the queue between full and empty, so that full pushes,
    // empty pops and the recursion flag are all reached often.
    task automatic random_words(int count);
        int  n;
        bit  filling;
        bit  push;
        filling = (sb.stored() < DEFAULT_CAPACITY / 2);
        for (n = 0; n < count; n++) begin
            if (sb.stored() == DEFAULT_CAPACITY && $urandom_range(2) == 0) filling = 1'b0;
            if (sb.stored() == 0 && $urandom_range(2) == 0) filling = 1'b1;
            if ($urandom_range(9) == 0)
                push = ($urandom_range(1) == 1);
            else
                push = filling ? ($urandom_range(99) < 75) : ($urandom_range(99) < 25);
            send_word(push ? OP_PUSH : OP_POP, pick_due(), TAG_W'($urandom_range(16'hFFFF)),
                      $urandom_range(9) != 0);
        end
    endtask

    // Main sequence.
    initial begin
        int k;
        sb        = new();
        cycles    = 0;
        send_idle = 23;
        recv_idle = 48;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_PUSH;
        m_tready  = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed words: empty pops, dropped pushes, extreme fields, equal times, full queue.
        send_word(OP_POP, '0, '0, 1'b1);
        send_word(OP_PUSH, TIME_MAX, TAG_MAX, 1'b0);
        send_word(OP_PUSH, TIME_MAX, TAG_MAX, 1'b1);
        send_word(OP_POP, TIME_MAX, TAG_MAX, 1'b0);
        send_word(OP_POP, '0, '0, 1'b0);
        send_word(OP_PUSH, 48'd100, 16'h1234, 1'b0);
        send_word(OP_PUSH, TIME_MAX, TAG_MAX, 1'b1);
        send_word(OP_PUSH, '0, '0, 1'b1);
        for (k = 0; k < 6; k++)
            send_word(OP_PUSH, 48'd100, TAG_W'(k + 1), 1'b1);
        for (k = 0; k < 8; k++)
            send_word(OP_PUSH, (k % 2) ? 48'hAAAA_AAAA_AAAA : 48'h5555_5555_5555,
                      (k % 2) ? 16'hAAAA : 16'h5555, 1'b1);
        send_word(OP_PUSH, 48'd50, 16'hBEEF, 1'b1);
        send_word(OP_PUSH, 48'd100, 16'hCAFE, 1'b0);
        send_word(OP_POP, '0, '0, 1'b1);
        send_word(OP_POP, '0, '0, 1'b1);

        // Random words under three idling patterns.
        random_words(300);
        send_idle = 48;
        recv_idle = 23;
        random_words(310);
        send_idle = 0;
        recv_idle = 0;
        random_words(315);
        s_tvalid = 1'b0;

        // Drain, then watch for any stray result word.
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
hdl/stpq_pkg.sv
hdl/stpq_cell.sv
hdl/stable_time_priority_queue.sv
tb/testbench.sv
